>>> sv/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

  localparam int BLK_W      = 16;
  localparam int NUM_BLOCKS = 4096;

  // Bitmap row geometry: 32 block bits per RAM row
  localparam int ROW_BITS  = 32;
  localparam int COL_W     = $clog2(ROW_BITS);
  localparam int ROWS      = (NUM_BLOCKS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W     = ROW_W + COL_W;
  localparam int LAST_BITS = NUM_BLOCKS - (ROWS - 1) * ROW_BITS;

  localparam logic [ROW_W-1:0]    LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [ROW_BITS-1:0] LAST_MASK = {ROW_BITS{1'b1}} >> (ROW_BITS - LAST_BITS);

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_RANGE    = 2'd2,
    STAT_NOT_USED = 2'd3
  } status_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_FREE_RANGE,
    S_FREE_RD,
    S_FREE_CHK,
    S_DONE
  } state_t;

  // Bits of a row that map to real blocks
  function automatic logic [ROW_BITS-1:0] row_mask(input logic [ROW_W-1:0] r);
    row_mask = (r == LAST_ROW) ? LAST_MASK : {ROW_BITS{1'b1}};
  endfunction

  // Index of the lowest clear bit
  function automatic logic [COL_W-1:0] first_zero(input logic [ROW_BITS-1:0] v);
    logic [COL_W-1:0] idx;
    idx = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (!v[i]) idx = COL_W'(i);
    end
    first_zero = idx;
  endfunction

endpackage

>>> sv/bba_ram.sv
`timescale 1ns / 1ps

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> sv/bitmap_block_allocator_core.sv
`timescale 1ns / 1ps

// First-fit block allocator over a used/free bitmap of NUM_BLOCKS data blocks,
// held in a RAM of 32-bit rows (ROWS = NUM_BLOCKS/32 rounded up, 128 rows by
// default). After reset the block runs a clearing pass, one row a cycle,
// with in_ready low; cfg writes are taken throughout. An allocate word reads
// rows from row 0 upwards, each row a RAM read, then a find-lowest-zero on
// the registered row data, and stops at the first row with a free block or
// at the last row when the bitmap is full. A free word runs a range check, a
// row read, a bit test and write-back, then the result; a block outside the
// data area goes from the range check straight to the result. The bitmap has
// a single RAM port pair and one word is in work at a time. A finished result
// sits in the output register, so the next word is accepted while it waits
// for out_ready. Status: 0 ok, 1 no free block, 2 block out of range,
// 3 block not allocated; on any error allocated_block is 0 and the bitmap is
// untouched. Changing first_data_block only remaps bit indices to block
// numbers; write it only while idle.

module bitmap_block_allocator_core (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_we,
  input  logic [bba_pkg::BLK_W-1:0] cfg_wdata,
  // request channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      kind,
  input  logic [bba_pkg::BLK_W-1:0] block_number,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bba_pkg::BLK_W-1:0] allocated_block,
  output logic [1:0]                status
);

  import bba_pkg::*;

  state_t state, state_next;

  logic [BLK_W-1:0] first_data_block;
  logic [BLK_W-1:0] blk;        // latched block number of a free word
  logic [ROW_W-1:0] row;        // clear / scan / free row pointer
  logic [COL_W-1:0] col;        // bit within row for a free word
  logic [BLK_W-1:0] res_block;
  status_t          res_status;

  // RAM port
  logic                ram_we;
  logic [ROW_W-1:0]    ram_waddr;
  logic [ROW_BITS-1:0] ram_wdata;
  logic [ROW_BITS-1:0] rd_data;

  // Row unit for allocate: masked row, lowest free bit
  logic [ROW_BITS-1:0] row_used;
  logic                row_has_free;
  logic [COL_W-1:0]    free_col;
  logic [BLK_W-1:0]    grant_block;

  // Free range check
  logic [BLK_W:0]      rel;
  logic                rel_bad;

  logic accept, out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign row_used     = rd_data | ~row_mask(row);
  assign row_has_free = (row_used != {ROW_BITS{1'b1}});
  assign free_col     = first_zero(row_used);
  assign grant_block  = first_data_block + {{(BLK_W - IDX_W){1'b0}}, row, free_col};

  assign rel     = {1'b0, blk} - {1'b0, first_data_block};
  assign rel_bad = rel[BLK_W] || (rel[BLK_W-1:0] >= BLK_W'(NUM_BLOCKS));

  bba_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (row),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:      if (row == LAST_ROW) state_next = S_IDLE;
      S_IDLE: begin
        if (accept) state_next = (kind == KIND_ALLOC) ? S_ALLOC_RD : S_FREE_RANGE;
      end
      S_ALLOC_RD:   state_next = S_ALLOC_CHK;
      S_ALLOC_CHK: begin
        if (row_has_free || row == LAST_ROW) state_next = S_DONE;
        else                                 state_next = S_ALLOC_RD;
      end
      S_FREE_RANGE: state_next = rel_bad ? S_DONE : S_FREE_RD;
      S_FREE_RD:    state_next = S_FREE_CHK;
      S_FREE_CHK:   state_next = S_DONE;
      S_DONE:       if (out_free) state_next = S_IDLE;
      default:      state_next = S_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = row;
    ram_wdata = '0;
    case (state)
      S_CLEAR:     ram_we = 1'b1;
      S_IDLE:      in_ready = 1'b1;
      S_ALLOC_CHK: begin
        ram_we    = row_has_free;
        ram_wdata = rd_data | (ROW_BITS'(1) << free_col);
      end
      S_FREE_CHK: begin
        ram_we    = rd_data[col];
        ram_wdata = rd_data & ~(ROW_BITS'(1) << col);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      row              <= '0;
      first_data_block <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) first_data_block <= cfg_wdata;

      case (state)
        S_CLEAR:     row <= (row == LAST_ROW) ? '0 : row + 1'b1;
        S_IDLE:      row <= '0;
        S_ALLOC_CHK: if (!row_has_free && row != LAST_ROW) row <= row + 1'b1;
        S_FREE_RANGE: begin
          row <= rel[IDX_W-1:COL_W];
        end
        default: ;
      endcase

      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready)              out_valid <= 1'b0;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (accept) blk <= block_number;
    case (state)
      S_ALLOC_CHK: begin
        if (row_has_free) begin
          res_block  <= grant_block;
          res_status <= STAT_OK;
        end else begin
          res_block  <= '0;
          res_status <= STAT_FULL;
        end
      end
      S_FREE_RANGE: begin
        col        <= rel[COL_W-1:0];
        res_block  <= '0;
        res_status <= STAT_RANGE;
      end
      S_FREE_CHK: begin
        res_block  <= '0;
        res_status <= rd_data[col] ? STAT_OK : STAT_NOT_USED;
      end
      S_DONE: begin
        if (out_free) begin
          allocated_block <= res_block;
          status          <= res_status;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == STAT_OK || allocated_block == '0))
    else $error("error result carries a block number");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_ALLOC_CHK || state == S_FREE_CHK))
    else $error("bitmap written outside clear or update");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("second word taken while one is in work");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished result not presented");

  a_clear_block: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (!in_ready && !out_valid))
    else $error("traffic during clearing pass");

endmodule

>>> verif/alloc_result_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the allocator, keeps its own copy of the block
// map and the data area base, and checks every result word in order.
module alloc_result_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [bba_pkg::BLK_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      kind,
  input  logic [bba_pkg::BLK_W-1:0] block_number,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [bba_pkg::BLK_W-1:0] allocated_block,
  input  logic [1:0]                status,
  output int                        fails = 0,
  output int                        owed_count = 0
);

  import bba_pkg::*;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    status_t          st;
  } reply_t;

  logic [NUM_BLOCKS-1:0] used_map;
  logic [BLK_W-1:0]      base_block;
  int                    low_free;    // every bit below this one is used
  reply_t                owed[$];

  // Carries out one request on the map copy and gives the answer due.
  function automatic reply_t serve(input kind_t op, input logic [BLK_W-1:0] blk);
    reply_t      r;
    int unsigned rel;
    int          slot;
    r.blk = '0;
    r.st  = STAT_OK;
    if (op == KIND_ALLOC) begin
      slot = low_free;
      while (slot < NUM_BLOCKS && used_map[slot]) slot++;
      low_free = slot;
      if (slot == NUM_BLOCKS) begin
        r.st = STAT_FULL;
      end else begin
        used_map[slot] = 1'b1;
        low_free       = slot + 1;
        r.blk          = BLK_W'(base_block + slot);   // wraps mod 2^16
      end
    end else if (blk < base_block) begin
      r.st = STAT_RANGE;
    end else begin
      rel = blk - base_block;
      if (rel >= NUM_BLOCKS) begin
        r.st = STAT_RANGE;
      end else if (!used_map[rel]) begin
        r.st = STAT_NOT_USED;
      end else begin
        used_map[rel] = 1'b0;
        if (rel < low_free) low_free = rel;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      used_map   = '0;
      base_block = '0;
      low_free   = 0;
      owed.delete();
    end else begin
      if (cfg_we) base_block = cfg_wdata;
      if (in_valid && in_ready) owed.push_back(serve(kind_t'(kind), block_number));
      if (out_valid && out_ready) begin
        if (owed.size() == 0) begin
          $error("result word with nothing owed: allocated_block %0d, status %0d",
                 allocated_block, status);
          fails++;
        end else begin
          want = owed.pop_front();
          if (allocated_block !== want.blk) begin
            $error("allocated_block: expected %0d, actual %0d", want.blk, allocated_block);
            fails++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, status);
            fails++;
          end
        end
      end
    end
    owed_count = owed.size();
  end

endmodule

>>> verif/bitmap_block_allocator_core_tb.sv
`timescale 1ns / 1ps

module bitmap_block_allocator_core_tb;
  import bba_pkg::*;

  localparam int RND_WORDS = 255;              // random words per random phase
  localparam int FILL_WORDS = 150;             // allocates in the fill run
  localparam int FREE_WORDS = FILL_WORDS + 10; // frees that sweep the run and past it
  localparam int WINDOW = 80;                  // low blocks that random frees aim at

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [BLK_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  kind_t            kind_w = KIND_ALLOC;
  logic [BLK_W-1:0] block_number = '0;
  logic             out_valid;
  logic             out_ready = 1'b1;
  logic [BLK_W-1:0] allocated_block;
  logic [1:0]       status;

  int               fail_total;
  int               owed_count;

  // Stimulus knobs; changed only at a falling edge between phases
  int               idle_pct = 0;
  int               stall_pct = 0;
  logic [BLK_W-1:0] base = '0;    // data area base last written

  always #2 clk = ~clk;

  bitmap_block_allocator_core DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind_w),
    .block_number    (block_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .allocated_block (allocated_block),
    .status          (status)
  );

  alloc_result_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .kind            (kind_w),
    .block_number    (block_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .allocated_block (allocated_block),
    .status          (status),
    .fails           (fail_total),
    .owed_count      (owed_count)
  );

  // Receiver: drops ready on a random share of cycles
  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  // Offers one word and holds it until taken. Valid is only dropped when an
  // idle gap comes first, so back-to-back words keep it high throughout.
  task automatic send_word(input kind_t k, input logic [BLK_W-1:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind_w       <= k;
    block_number <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  // Called at the edge that took the last word; returns at a falling edge
  // once every owed result has come back.
  task automatic end_phase();
    in_valid <= 1'b0;
    do @(negedge clk); while (owed_count != 0);
  endtask

  // Register write; only while the block is idle
  task automatic set_base(input logic [BLK_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    base       = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly allocate/free pairs on the low end of the map, so the map stays
  // sparse and allocates return quickly; the rest is noise around the edges
  // of the data area and fully random block numbers.
  task automatic random_phase(input int gap_pct, input int hold_pct,
                              input logic [BLK_W-1:0] b);
    int               pick;
    logic [BLK_W-1:0] blk;
    idle_pct  = gap_pct;
    stall_pct = hold_pct;
    set_base(b);
    repeat (RND_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_word(KIND_ALLOC, BLK_W'($urandom));
      end else if (pick < 85) begin
        send_word(KIND_FREE, BLK_W'(base + $urandom_range(0, WINDOW - 1)));
      end else begin
        case ($urandom_range(0, 3))
          0:       blk = BLK_W'($urandom);
          1:       blk = base - 1'b1;
          2:       blk = BLK_W'(base + NUM_BLOCKS - 1);
          default: blk = BLK_W'(base + NUM_BLOCKS);
        endcase
        send_word(KIND_FREE, blk);
      end
    end
    end_phase();
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Data area at block 0. The clearing pass holds off the first word.
    set_base(16'd0);
    send_word(KIND_FREE, 16'd0);        // free of a free block
    send_word(KIND_ALLOC, 16'hFFFF);    // -> 0
    send_word(KIND_ALLOC, 16'h0000);    // -> 1
    send_word(KIND_FREE, 16'd1);
    send_word(KIND_FREE, 16'd1);        // now free again
    send_word(KIND_ALLOC, 16'h5A5A);    // lowest hole, -> 1
    send_word(KIND_FREE, 16'd4096);     // just past the data area
    send_word(KIND_FREE, 16'hFFFF);
    send_word(KIND_FREE, 16'd4095);     // last block, never used
    end_phase();

    // Base at the top of its range
    set_base(16'd57343);
    send_word(KIND_ALLOC, 16'd0);       // bit 2
    send_word(KIND_FREE, 16'd57342);    // just below the data area
    send_word(KIND_FREE, 16'd0);
    send_word(KIND_FREE, 16'd57343);    // bit 0, set under the old base
    send_word(KIND_FREE, 16'd61439);    // one past the end
    send_word(KIND_FREE, 16'd61438);    // last block, free
    send_word(KIND_ALLOC, 16'd0);       // refills bit 0
    end_phase();

    // Base above its range: block numbers wrap round 2^16
    set_base(16'hFFFF);
    send_word(KIND_ALLOC, 16'd0);       // bit 3 -> 2
    send_word(KIND_FREE, 16'd2);        // below the base once wrapped
    send_word(KIND_FREE, 16'hFFFF);     // bit 0
    send_word(KIND_ALLOC, 16'd0);       // -> 0xFFFF
    send_word(KIND_ALLOC, 16'd0);       // bit 4 -> 3
    end_phase();

    // Fill a run of low blocks across several rows, punch two holes and
    // refill them lowest first, then free the run and a few blocks past it.
    set_base(16'd4000);
    repeat (FILL_WORDS) send_word(KIND_ALLOC, BLK_W'($urandom));
    send_word(KIND_FREE, BLK_W'(base + 100));
    send_word(KIND_FREE, BLK_W'(base + 20));
    send_word(KIND_ALLOC, 16'd0);
    send_word(KIND_ALLOC, 16'd0);
    send_word(KIND_ALLOC, 16'd0);
    for (int i = 0; i < FREE_WORDS; i++) send_word(KIND_FREE, BLK_W'(base + i));
    end_phase();

    random_phase(0, 0, BLK_W'($urandom_range(0, 57343)));
    random_phase(59, 0, 16'd0);
    random_phase(0, 59, 16'd57343);
    random_phase(27, 27, BLK_W'($urandom_range(0, 57343)));

    // Room for a stray late result, a full map scan at most
    repeat (2 * ROWS + 8) @(posedge clk);
    @(negedge clk);
    if (fail_total == 0 && owed_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hang guard, set several times longer than the slowest legal run even if
  // every word scanned the whole map under the heaviest stalls
  initial begin : watchdog
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
